// ===== hw/rtl/coag_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package coag_pkg;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_DATA  = 1'b1
  } cmd_e;

  typedef enum logic [3:0] {
    MODE_IMPL = 4'd0,
    MODE_ACC  = 4'd1,
    MODE_IMM  = 4'd2,
    MODE_ZP   = 4'd3,
    MODE_ZPX  = 4'd4,
    MODE_ZPY  = 4'd5,
    MODE_ABS  = 4'd6,
    MODE_ABSX = 4'd7,
    MODE_ABSY = 4'd8,
    MODE_REL  = 4'd9,
    MODE_IND  = 4'd10,
    MODE_IZX  = 4'd11,
    MODE_IZY  = 4'd12
  } mode_e;

  typedef enum logic [1:0] {
    KIND_REQ  = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  localparam logic [15:0] PageMask = 16'hFF00;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] request_address;
    logic [15:0] effective_address;
    logic [7:0]  operand_value;
    logic        immediate_flag;
    logic        crossed_page;
    logic [15:0] next_pc;
  } result_t;

  function automatic logic crosses(logic [15:0] a, logic [15:0] b);
    return ((a ^ b) & PageMask) != 16'h0000;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/coag_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

module coag_step (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            accept_i,
  input  wire logic            cmd_i,
  input  wire logic [3:0]      mode_i,
  input  wire logic [15:0]     program_counter_i,
  input  wire logic [7:0]      index_x_i,
  input  wire logic [7:0]      index_y_i,
  input  wire logic [7:0]      read_data_i,
  output coag_pkg::result_t    result_o
);
  import coag_pkg::*;

  localparam logic [2:0] StepIdle  = 3'd0;
  localparam logic [2:0] StepOne   = 3'd1;
  localparam logic [2:0] StepTwo   = 3'd2;
  localparam logic [2:0] StepThree = 3'd3;
  localparam logic [2:0] StepFour  = 3'd4;

  logic [2:0]  step_q, step_d;
  mode_e       mode_q, mode_d;
  logic [15:0] pc_q, pc_d;
  logic [7:0]  x_q, x_d;
  logic [7:0]  y_q, y_d;
  logic [7:0]  low_q, low_d;
  logic [15:0] ptr_q, ptr_d;

  logic [15:0] pc1, pc2, word, ea_idx, ea_rel, ptr_next;
  logic [7:0]  idx, zp_x;
  result_t     res;

  assign pc1      = pc_q + 16'd1;
  assign pc2      = pc_q + 16'd2;
  assign word     = {read_data_i, low_q};
  assign idx      = (mode_q == MODE_ABSX) ? x_q : y_q;
  assign ea_idx   = word + {8'h00, idx};
  assign ea_rel   = pc1 + {{8{read_data_i[7]}}, read_data_i};
  assign zp_x     = read_data_i + x_q;
  // The indirect pointer's high byte comes from the same page as its low byte.
  assign ptr_next = (ptr_q & PageMask) | {8'h00, ptr_q[7:0] + 8'd1};

  always_comb begin
    step_d = step_q;
    mode_d = mode_q;
    pc_d   = pc_q;
    x_d    = x_q;
    y_d    = y_q;
    low_d  = low_q;
    ptr_d  = ptr_q;
    res    = '0;
    res.kind = KIND_ERR;

    if (cmd_e'(cmd_i) == CMD_START) begin
      mode_d = mode_e'(mode_i);
      pc_d   = program_counter_i;
      x_d    = index_x_i;
      y_d    = index_y_i;
      low_d  = 8'h00;
      ptr_d  = 16'h0000;
      if (mode_i < 4'(MODE_IMM) || mode_i > 4'(MODE_IZY)) begin
        res.kind    = KIND_DONE;
        res.next_pc = program_counter_i;
        step_d      = StepIdle;
      end else begin
        res.kind            = KIND_REQ;
        res.request_address = program_counter_i;
        step_d              = StepOne;
      end
    end else if (step_q != StepIdle) begin
      // Anything not matched below is an out-of-sequence step.
      step_d = StepIdle;
      case (mode_q)
        MODE_IMM: begin
          if (step_q == StepOne) begin
            res.kind           = KIND_DONE;
            res.operand_value  = read_data_i;
            res.immediate_flag = 1'b1;
            res.next_pc        = pc1;
          end
        end
        MODE_ZP, MODE_ZPX, MODE_ZPY: begin
          if (step_q == StepOne) begin
            res.kind    = KIND_DONE;
            res.next_pc = pc1;
            case (mode_q)
              MODE_ZPX: res.effective_address = {8'h00, zp_x};
              MODE_ZPY: res.effective_address = {8'h00, read_data_i + y_q};
              default:  res.effective_address = {8'h00, read_data_i};
            endcase
          end
        end
        MODE_ABS, MODE_ABSX, MODE_ABSY: begin
          if (step_q == StepOne) begin
            low_d               = read_data_i;
            res.kind            = KIND_REQ;
            res.request_address = pc1;
            step_d              = StepTwo;
          end else if (step_q == StepTwo) begin
            res.kind    = KIND_DONE;
            res.next_pc = pc2;
            if (mode_q == MODE_ABS) begin
              res.effective_address = word;
            end else begin
              res.effective_address = ea_idx;
              res.crossed_page      = crosses(word, ea_idx);
            end
          end
        end
        MODE_REL: begin
          if (step_q == StepOne) begin
            res.kind              = KIND_DONE;
            res.effective_address = ea_rel;
            res.crossed_page      = crosses(pc1, ea_rel);
            res.next_pc           = pc1;
          end
        end
        MODE_IND: begin
          res.kind = KIND_REQ;
          case (step_q)
            StepOne: begin
              low_d               = read_data_i;
              res.request_address = pc1;
              step_d              = StepTwo;
            end
            StepTwo: begin
              ptr_d               = word;
              res.request_address = word;
              step_d              = StepThree;
            end
            StepThree: begin
              low_d               = read_data_i;
              res.request_address = ptr_next;
              step_d              = StepFour;
            end
            StepFour: begin
              res.kind              = KIND_DONE;
              res.effective_address = word;
              res.next_pc           = pc2;
            end
            default: begin
              res.kind = KIND_ERR;
            end
          endcase
        end
        MODE_IZX, MODE_IZY: begin
          res.kind = KIND_REQ;
          case (step_q)
            StepOne: begin
              ptr_d = (mode_q == MODE_IZX) ? {8'h00, zp_x} : {8'h00, read_data_i};
              res.request_address = ptr_d;
              step_d              = StepTwo;
            end
            StepTwo: begin
              low_d               = read_data_i;
              res.request_address = {8'h00, ptr_q[7:0] + 8'd1};
              step_d              = StepThree;
            end
            StepThree: begin
              res.kind    = KIND_DONE;
              res.next_pc = pc1;
              if (mode_q == MODE_IZX) begin
                res.effective_address = word;
              end else begin
                res.effective_address = word + {8'h00, y_q};
                res.crossed_page      = crosses(word, word + {8'h00, y_q});
              end
            end
            default: begin
              res.kind = KIND_ERR;
            end
          endcase
        end
        default: begin
          res.kind = KIND_ERR;
        end
      endcase
    end
  end

  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StepIdle;
      mode_q <= MODE_IMPL;
      pc_q   <= 16'h0000;
      x_q    <= 8'h00;
      y_q    <= 8'h00;
      low_q  <= 8'h00;
      ptr_q  <= 16'h0000;
    end else if (accept_i) begin
      step_q <= step_d;
      mode_q <= mode_d;
      pc_q   <= pc_d;
      x_q    <= x_d;
      y_q    <= y_d;
      low_q  <= low_d;
      ptr_q  <= ptr_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/coag_out_buf.sv =====
`timescale 1ns / 1ps
`default_nettype none

module coag_out_buf (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire coag_pkg::result_t result_i,
  output logic                   full_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output coag_pkg::result_t      result_o
);
  import coag_pkg::*;

  logic    out_valid_q;
  logic    skid_valid_q;
  result_t out_q;
  result_t skid_q;
  logic    out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      // While the skid entry is full the input side is stalled.
      out_valid_q  <= skid_valid_q || accept_i;
      skid_valid_q <= 1'b0;
    end else if (accept_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : result_i;
    end else if (accept_i) begin
      skid_q <= result_i;
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

endmodule

`default_nettype wire

// ===== hw/rtl/cpu_operand_address_generator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Operand address sequencer for the thirteen 6502 addressing modes. A start
// request (cmd 0) latches mode, PC, X and Y; every request, start or memory
// byte (cmd 1), yields exactly one result, registered in the output buffer:
// a memory read request, a finished result with the effective address, or an
// error for data that arrives with no read outstanding. One request is taken
// every cycle unless in_stall_o is high; the step logic updates the sequencer
// state in the same cycle it accepts a request, and a two-entry output buffer
// keeps the input open for one more request while a result is held.
module cpu_operand_address_generator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        cmd_i,
  input  wire logic [3:0]  mode_i,
  input  wire logic [15:0] program_counter_i,
  input  wire logic [7:0]  index_x_i,
  input  wire logic [7:0]  index_y_i,
  input  wire logic [7:0]  read_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       kind_o,
  output logic [15:0]      request_address_o,
  output logic [15:0]      effective_address_o,
  output logic [7:0]       operand_value_o,
  output logic             immediate_flag_o,
  output logic             crossed_page_o,
  output logic [15:0]      next_pc_o
);
  import coag_pkg::*;

  logic    accept;
  logic    full;
  result_t step_res;
  result_t out_res;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  coag_step u_step (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (accept),
    .cmd_i             (cmd_i),
    .mode_i            (mode_i),
    .program_counter_i (program_counter_i),
    .index_x_i         (index_x_i),
    .index_y_i         (index_y_i),
    .read_data_i       (read_data_i),
    .result_o          (step_res)
  );

  coag_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .result_i    (step_res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (out_res)
  );

  assign kind_o              = out_res.kind;
  assign request_address_o   = out_res.request_address;
  assign effective_address_o = out_res.effective_address;
  assign operand_value_o     = out_res.operand_value;
  assign immediate_flag_o    = out_res.immediate_flag;
  assign crossed_page_o      = out_res.crossed_page;
  assign next_pc_o           = out_res.next_pc;

endmodule

`default_nettype wire
